// ===== rtl/mtn_pkg.sv =====
// shared types, keyword tables and helpers for the media type normalizer
package mtn_pkg;

  localparam int NUM_TYPES = 5;
  localparam int MAX_SUBS  = 6;

  localparam logic [1:0] VERDICT_KEEP  = 2'd0;
  localparam logic [1:0] VERDICT_PLAIN = 2'd1;
  localparam logic [1:0] VERDICT_OCTET = 2'd2;

  localparam logic [2:0] TYPE_TEXT = 3'd0;

  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
  localparam logic [7:0] CASE_FOLD  = 8'h20;

  localparam logic [3:0] POS_MAX = 4'd15;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_SLASH,
    PH_SUB,
    PH_SETTLED
  } phase_t;

  // keyword held right-justified, first character at the highest used byte
  typedef logic [127:0] kw_t;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       end_req;
  } mtn_req_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       type_found;
    logic [2:0] type_index;
    logic       subtype_found;
    logic [2:0] subtype_index;
    logic       bare_type;
  } mtn_res_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] position;
    logic [4:0] type_alive;
    logic [2:0] matched_type;
    logic [5:0] subtype_alive;
    logic [2:0] matched_subtype;
    logic       subtype_hit;
    logic [1:0] settled_verdict;
    logic       seen_any;
  } mtn_state_t;

  localparam mtn_state_t STATE_RESET = '{
    phase:           PH_TYPE,
    position:        4'd0,
    type_alive:      5'h1f,
    matched_type:    3'd0,
    subtype_alive:   6'h3f,
    matched_subtype: 3'd0,
    subtype_hit:     1'b0,
    settled_verdict: VERDICT_KEEP,
    seen_any:        1'b0
  };

  localparam kw_t TYPE_NAME [NUM_TYPES] = '{
    kw_t'("text"), kw_t'("image"), kw_t'("audio"), kw_t'("video"), kw_t'("application")
  };
  localparam logic [3:0] TYPE_LEN [NUM_TYPES] = '{4'd4, 4'd5, 4'd5, 4'd5, 4'd11};

  // unused slots have length zero and never match
  localparam kw_t SUB_NAME [NUM_TYPES][MAX_SUBS] = '{
    '{kw_t'("plain"), kw_t'(""), kw_t'(""), kw_t'(""), kw_t'(""), kw_t'("")},
    '{kw_t'("jpeg"), kw_t'("png"), kw_t'("gif"), kw_t'("bmp"), kw_t'("webp"), kw_t'("")},
    '{kw_t'("basic"), kw_t'("midi"), kw_t'("wav"), kw_t'("mpeg"), kw_t'("webm"),
      kw_t'("ogg")},
    '{kw_t'("webm"), kw_t'("ogg"), kw_t'(""), kw_t'(""), kw_t'(""), kw_t'("")},
    '{kw_t'("octet-stream"), kw_t'("postscript"), kw_t'(""), kw_t'(""), kw_t'(""),
      kw_t'("")}
  };
  localparam logic [3:0] SUB_LEN [NUM_TYPES][MAX_SUBS] = '{
    '{4'd5,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd4,  4'd3,  4'd3, 4'd3, 4'd4, 4'd0},
    '{4'd5,  4'd4,  4'd3, 4'd4, 4'd4, 4'd3},
    '{4'd4,  4'd3,  4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd12, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  // character at pos of a keyword of length len; only meaningful for pos < len
  function automatic logic [7:0] kw_char(kw_t s, logic [3:0] len, logic [3:0] pos);
    logic [3:0] idx;
    idx = len - 4'd1 - pos;
    return s[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] fold(logic [7:0] b);
    return (b >= CHAR_UC_A && b <= CHAR_UC_Z) ? b + CASE_FOLD : b;
  endfunction

endpackage

// ===== rtl/mtn_step.sv =====
// next-state and verdict logic for one transaction of the normalizer
module mtn_step (
  input  mtn_pkg::mtn_state_t cur,
  input  mtn_pkg::mtn_req_t   req,
  output mtn_pkg::mtn_state_t nxt,
  output mtn_pkg::mtn_res_t   res
);
  import mtn_pkg::*;

  logic [7:0] c;
  logic [3:0] pos_inc;
  logic [4:0] t_alive;
  logic [5:0] s_alive;
  logic [2:0] tsel;
  logic       t_done;
  logic [2:0] t_idx;
  logic       s_done;
  logic [2:0] s_idx;
  logic       tf;

  assign c       = fold(req.byte_req);
  assign pos_inc = (cur.position == POS_MAX) ? POS_MAX : cur.position + 4'd1;
  assign tsel    = (cur.matched_type < 3'(NUM_TYPES)) ? cur.matched_type : TYPE_TEXT;

  // parallel prefix compare against every type and every subtype of the matched type
  always_comb begin
    t_alive = '0;
    s_alive = '0;
    t_done  = 1'b0;
    t_idx   = '0;
    s_done  = 1'b0;
    s_idx   = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      t_alive[i] = cur.type_alive[i] && (cur.position < TYPE_LEN[i]) &&
                   (kw_char(TYPE_NAME[i], TYPE_LEN[i], cur.position) == c);
    end
    for (int j = 0; j < MAX_SUBS; j++) begin
      s_alive[j] = cur.subtype_alive[j] && (cur.position < SUB_LEN[tsel][j]) &&
                   (kw_char(SUB_NAME[tsel][j], SUB_LEN[tsel][j], cur.position) == c);
    end
    // lowest index wins
    for (int i = NUM_TYPES - 1; i >= 0; i--) begin
      if (t_alive[i] && TYPE_LEN[i] == pos_inc) begin
        t_done = 1'b1;
        t_idx  = 3'(i);
      end
    end
    for (int j = MAX_SUBS - 1; j >= 0; j--) begin
      if (s_alive[j] && SUB_LEN[tsel][j] == pos_inc) begin
        s_done = 1'b1;
        s_idx  = 3'(j);
      end
    end
  end

  always_comb begin
    nxt = cur;
    if (req.end_req) begin
      nxt = STATE_RESET;
    end else begin
      nxt.seen_any = 1'b1;
      unique case (cur.phase)
        PH_TYPE: begin
          nxt.type_alive = t_alive;
          nxt.position   = pos_inc;
          if (t_alive == '0) begin
            nxt.settled_verdict = VERDICT_OCTET;
            nxt.phase           = PH_SETTLED;
          end else if (t_done) begin
            nxt.matched_type = t_idx;
            nxt.type_alive   = 5'b00001 << t_idx;
            nxt.phase        = PH_SLASH;
          end
        end
        PH_SLASH: begin
          if (c == CHAR_SLASH) begin
            nxt.phase         = PH_SUB;
            nxt.position      = '0;
            nxt.subtype_alive = '1;
          end else begin
            nxt.settled_verdict = VERDICT_OCTET;
            nxt.phase           = PH_SETTLED;
          end
        end
        PH_SUB: begin
          nxt.subtype_alive = s_alive;
          nxt.position      = pos_inc;
          if (s_alive == '0) begin
            nxt.settled_verdict = (cur.matched_type == TYPE_TEXT) ? VERDICT_PLAIN
                                                                  : VERDICT_OCTET;
            nxt.phase           = PH_SETTLED;
          end else if (s_done) begin
            nxt.matched_subtype = s_idx;
            nxt.subtype_hit     = 1'b1;
            nxt.settled_verdict = VERDICT_KEEP;
            nxt.phase           = PH_SETTLED;
          end
        end
        PH_SETTLED: begin
          nxt.position = cur.position;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  assign tf = (cur.phase != PH_TYPE) && (cur.type_alive != '0);

  always_comb begin
    res               = '0;
    res.type_found    = tf;
    res.type_index    = tf ? cur.matched_type : 3'd0;
    res.subtype_found = cur.subtype_hit;
    res.subtype_index = cur.subtype_hit ? cur.matched_subtype : 3'd0;
    unique case (cur.phase)
      PH_TYPE:    res.verdict = cur.seen_any ? VERDICT_OCTET : VERDICT_KEEP;
      PH_SLASH: begin
        res.verdict   = VERDICT_KEEP;
        res.bare_type = 1'b1;
      end
      PH_SUB:     res.verdict = (cur.matched_type == TYPE_TEXT) ? VERDICT_PLAIN
                                                                : VERDICT_OCTET;
      PH_SETTLED: res.verdict = cur.settled_verdict;
      default:    res.verdict = VERDICT_KEEP;
    endcase
  end

endmodule

// ===== rtl/media_type_normalizer.sv =====
// top level of the media type normalizer: input register, match state, result register
//
// Takes a Content-Type value one byte per transaction on req (end_req closes the value)
// and gives one verdict on res for each end transaction, then starts over for the next
// value. One transaction is taken every clock while req_stall is low; an end transaction
// is held in the input register, its verdict then in the result register. All keyword
// compares for a byte run in parallel in the single logic stage between the input register
// and the match state / result register. A byte transaction never waits on res; only an
// end transaction waits while res is full and stalled.
module media_type_normalizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  mtn_pkg::mtn_req_t req,
  output logic              res_valid,
  input  logic              res_stall,
  output mtn_pkg::mtn_res_t res
);
  import mtn_pkg::*;

  logic       in_full;
  mtn_req_t   in_q;
  mtn_state_t st;
  mtn_state_t st_next;
  mtn_res_t   step_res;
  mtn_res_t   out_q;
  logic       out_full;
  logic       advance;

  mtn_step u_step (
    .cur (st),
    .req (in_q),
    .nxt (st_next),
    .res (step_res)
  );

  assign advance   = in_full && (!in_q.end_req || !out_full || !res_stall);
  assign req_stall = in_full && !advance;
  assign res_valid = out_full;
  assign res       = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance && in_q.end_req) begin
      out_full <= 1'b1;
    end else if (!res_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q.end_req) begin
      out_q <= step_res;
    end
  end

endmodule
